// File: src/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg: shared types and constants for the PNG scanline unfilter
// Sizes, format, filter and CSR codes, front-to-back sample record and paeth().
// ----------------------------------------------------------------------------
package psu_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int PALETTE_DEPTH = 256;
   localparam int LINE_DEPTH    = MAX_WIDTH * 4;
   localparam int LINE_AW       = $clog2(LINE_DEPTH);
   localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   localparam logic [2:0] FMT_GRAY = 3'd0;
   localparam logic [2:0] FMT_RGB  = 3'd1;
   localparam logic [2:0] FMT_PAL  = 3'd2;
   localparam logic [2:0] FMT_GA   = 3'd3;
   localparam logic [2:0] FMT_RGBA = 3'd4;

   localparam logic [2:0] FLT_NONE  = 3'd0;
   localparam logic [2:0] FLT_SUB   = 3'd1;
   localparam logic [2:0] FLT_UP    = 3'd2;
   localparam logic [2:0] FLT_AVG   = 3'd3;
   localparam logic [2:0] FLT_PAETH = 3'd4;

   localparam logic [1:0] ADDR_WIDTH  = 2'd0;
   localparam logic [1:0] ADDR_HEIGHT = 2'd1;
   localparam logic [1:0] ADDR_FORMAT = 2'd2;

   // one classified sample byte handed from front to back
   typedef struct packed {
      logic [7:0]  data;
      logic [2:0]  filter;
      logic        row_start;  // first sample of a row: history cleared
      logic        first_row;
      logic        in_store;   // column lies inside the line store
      logic [1:0]  lane;       // byte position inside the pixel
      logic        pix_done;
      logic        eor;
      logic        eoi;
      logic [2:0]  fmt;
      logic [2:0]  bpp;
   } smp_type;

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [10:0] p, da, db, dc;
      p  = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({3'b0, c});
      da = p - $signed({3'b0, a});
      db = p - $signed({3'b0, b});
      dc = p - $signed({3'b0, c});
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

endpackage

// File: src/psu_front.sv
// ----------------------------------------------------------------------------
// psu_front: request classifier
// Tracks byte column and row, flags pixel, row and image ends, strobes pal_we.
// ----------------------------------------------------------------------------
module psu_front import psu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 mode,
   input  logic [7:0]           data_byte,
   input  logic [12:0]          cfg_width,
   input  logic [15:0]          cfg_height,
   input  logic [2:0]           cfg_format,
   output logic                 smp_valid,
   output smp_type              smp,
   output logic [LINE_AW-1:0]   smp_col,
   output logic                 pal_we
);
   logic [14:0] col_ff, col_in;     // 0 = filter byte awaited
   logic [15:0] row_ff, row_in;
   logic [2:0]  filt_ff, filt_in;
   logic        rs_ff, rs_in;
   logic [1:0]  m3_ff, m3_in;       // sample offset in the row, modulo 3
   logic [1:0]  lane;               // sample offset modulo the current bpp
   logic [2:0]  bpp;
   logic [12:0] width;
   logic [15:0] height;
   logic [14:0] rowbytes, idx;
   logic        done, eor, eoi;

   always_comb begin
      unique case (cfg_format)
         FMT_RGB:  bpp = 3'd3;
         FMT_GA:   bpp = 3'd2;
         FMT_RGBA: bpp = 3'd4;
         default:  bpp = 3'd1;
      endcase
      width  = (cfg_width == 13'd0) ? 13'd1 :
               (cfg_width > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : cfg_width;
      height = (cfg_height == 16'd0) ? 16'd1 : cfg_height;
      rowbytes = 15'(width * bpp);
      idx  = col_ff - 15'd1;
      // lane follows the current bpp, so a format change mid-row is honored
      unique case (bpp)
         3'd3:    lane = m3_ff;
         3'd2:    lane = {1'b0, idx[0]};
         3'd4:    lane = idx[1:0];
         default: lane = 2'd0;
      endcase
      done = ({1'b0, lane} == bpp - 3'd1);
      eor  = done && (idx + 15'd1 >= rowbytes);
      eoi  = eor && (17'(row_ff) + 17'd1 >= 17'(height));
   end

   assign pal_we    = in_valid && mode;
   assign smp_valid = in_valid && !mode && (col_ff != 15'd0);
   assign smp_col   = idx[LINE_AW-1:0];
   always_comb begin
      smp.data      = data_byte;
      smp.filter    = filt_ff;
      smp.row_start = rs_ff;
      smp.first_row = (row_ff == 16'd0);
      smp.in_store  = (idx < 15'(LINE_DEPTH));
      smp.lane      = lane;
      smp.pix_done  = done;
      smp.eor       = eor;
      smp.eoi       = eoi;
      smp.fmt       = cfg_format;
      smp.bpp       = bpp;
   end

   always_comb begin
      col_in = col_ff; row_in = row_ff; filt_in = filt_ff;
      rs_in = rs_ff; m3_in = m3_ff;
      if (in_valid && !mode) begin
         if (col_ff == 15'd0) begin
            filt_in = (data_byte <= 8'd4) ? data_byte[2:0] : FLT_NONE;
            col_in = 15'd1; rs_in = 1'b1; m3_in = 2'd0;
         end else begin
            rs_in = 1'b0;
            m3_in = (m3_ff == 2'd2) ? 2'd0 : m3_ff + 2'd1;
            if (eor) begin
               col_in = 15'd0;
               row_in = eoi ? 16'd0 : row_ff + 16'd1;
            end else begin
               col_in = col_ff + 15'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; filt_ff <= FLT_NONE;
         rs_ff <= 1'b0; m3_ff <= '0;
      end else begin
         col_ff <= col_in; row_ff <= row_in; filt_ff <= filt_in;
         rs_ff <= rs_in; m3_ff <= m3_in;
      end
   end
endmodule

// File: src/psu_back.sv
// ----------------------------------------------------------------------------
// psu_back: reconstruction and pixel conversion
// Stage 1 reads the line store, unfilters and converts; stage 2 reads palette.
// ----------------------------------------------------------------------------
module psu_back import psu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 smp_valid,
   input  smp_type              smp,
   input  logic [LINE_AW-1:0]   smp_col,
   input  logic                 pal_we,
   input  logic [7:0]           pal_idx,
   input  logic [23:0]          pal_color,
   input  logic                 out_ready,
   output logic                 out_valid,
   output logic [31:0]          out_pixel,
   output logic                 out_eor,
   output logic                 out_eoi,
   output logic                 accept_ok
);
   logic [7:0]  line_mem [LINE_DEPTH];
   logic [23:0] pal_mem  [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] pal_vld_ff;

   // stage 1: up byte read in flight
   logic        s1v_ff;
   smp_type     s1_ff;
   logic [LINE_AW-1:0] s1col_ff;
   logic [7:0]  uprd_ff;

   // history of reconstructed bytes and bytes above
   logic [7:0]  rb_ff [4];
   logic [7:0]  ru_ff [4];
   logic [23:0] asm_ff, asm_in;

   // stage 2 holding a pending palette lookup
   logic        s2v_ff;
   logic        s2pal_ff;
   logic [7:0]  s2idx_ff;
   logic [31:0] s2pix_ff;
   logic        s2eor_ff, s2eoi_ff;
   logic [23:0] palrd_ff;
   logic        palvrd_ff;

   // output register
   logic        ov_ff;
   logic [31:0] op_ff;
   logic        oeor_ff, oeoi_ff;

   logic        adv_s2, adv_s1, adv_in;
   logic [7:0]  up, left, ul, pred, recon;
   logic [7:0]  lb, ub;
   logic [31:0] pix;
   logic        s2_to_out;

   // forwarding: stage 1 column last written by a byte still in flight
   logic        fwd_hit;
   logic [7:0]  fwd_byte;

   assign s2_to_out = !ov_ff || out_ready;
   assign adv_s2    = s2_to_out;
   assign adv_s1    = !s2v_ff || adv_s2;
   assign adv_in    = !s1v_ff || adv_s1;
   assign accept_ok = adv_in;

   // same column is never in stage 1 twice in a row, so no forwarding needed
   assign fwd_hit  = 1'b0;
   assign fwd_byte = 8'd0;

   always_comb begin
      lb = s1_ff.row_start ? 8'd0 : rb_ff[s1_ff.bpp[1:0] - 2'd1];
      ub = s1_ff.row_start ? 8'd0 : ru_ff[s1_ff.bpp[1:0] - 2'd1];
      up = (!s1_ff.first_row && s1_ff.in_store) ? (fwd_hit ? fwd_byte : uprd_ff) : 8'd0;
      left = lb; ul = ub;
      unique case (s1_ff.filter)
         FLT_SUB:   pred = left;
         FLT_UP:    pred = up;
         FLT_AVG:   pred = 8'(({1'b0, left} + {1'b0, up}) >> 1);
         FLT_PAETH: pred = paeth(left, up, ul);
         default:   pred = 8'd0;
      endcase
      recon = s1_ff.data + pred;
      asm_in = s1_ff.row_start ? 24'd0 : asm_ff;
      unique case (s1_ff.fmt)
         FMT_RGB:  pix = {8'hff, recon, asm_in[15:0]};
         FMT_GA:   pix = {recon, asm_in[7:0], asm_in[7:0], asm_in[7:0]};
         FMT_RGBA: pix = {recon, asm_in};
         default:  pix = {8'hff, recon, recon, recon};
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv_in && smp_valid) uprd_ff <= line_mem[smp_col];
      if (adv_s1 && s1v_ff && s1_ff.in_store) line_mem[s1col_ff] <= recon;
      if (pal_we && (9'(pal_idx) < 9'(PALETTE_DEPTH))) pal_mem[pal_idx[PAL_AW-1:0]] <= pal_color;
      if (adv_s1 && s1v_ff) begin
         palrd_ff  <= pal_mem[recon[PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
         s1v_ff <= 1'b0; s2v_ff <= 1'b0; ov_ff <= 1'b0;
         asm_ff <= '0;
         for (int k = 0; k < 4; k++) begin rb_ff[k] <= '0; ru_ff[k] <= '0; end
      end else begin
         if (pal_we && (9'(pal_idx) < 9'(PALETTE_DEPTH)))
            pal_vld_ff[pal_idx[PAL_AW-1:0]] <= 1'b1;
         if (adv_in) begin
            s1v_ff <= smp_valid;
            if (smp_valid) begin s1_ff <= smp; s1col_ff <= smp_col; end
         end else if (adv_s1) s1v_ff <= 1'b0;
         if (adv_s1) begin
            s2v_ff <= s1v_ff && s1_ff.pix_done;
            if (s1v_ff) begin
               rb_ff[0] <= recon; ru_ff[0] <= up;
               for (int k = 1; k < 4; k++) begin
                  rb_ff[k] <= s1_ff.row_start ? 8'd0 : rb_ff[k-1];
                  ru_ff[k] <= s1_ff.row_start ? 8'd0 : ru_ff[k-1];
               end
               asm_ff <= s1_ff.pix_done ? 24'd0 :
                         (asm_in | (24'(recon) << {s1_ff.lane, 3'b000}));
               s2pal_ff <= (s1_ff.fmt == FMT_PAL);
               s2idx_ff <= recon;
               s2pix_ff <= pix;
               s2eor_ff <= s1_ff.eor; s2eoi_ff <= s1_ff.eoi;
               palvrd_ff <= (9'(recon) < 9'(PALETTE_DEPTH)) &&
                            pal_vld_ff[recon[PAL_AW-1:0]];
            end
         end else if (adv_s2) s2v_ff <= 1'b0;
         if (s2_to_out) begin
            ov_ff <= s2v_ff;
            if (s2v_ff) begin
               op_ff <= s2pal_ff ? (palvrd_ff ? {8'hff, palrd_ff} : 32'd0) : s2pix_ff;
               oeor_ff <= s2eor_ff; oeoi_ff <= s2eoi_ff;
            end
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_pixel = op_ff;
   assign out_eor   = oeor_ff;
   assign out_eoi   = oeoi_ff;
   logic unused_idx;
   assign unused_idx = ^s2idx_ff;
endmodule

// File: src/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter: PNG row unfilter and RGBA converter
// Undoes PNG filters on an inflated 8-bit stream and emits RGBA pixels.
// ----------------------------------------------------------------------------
// One request a cycle is taken unless the output stalls; a pixel passes stages
// 1 and 2 and the output register after its last byte. The rate is set by the
// single line store port pair (one read, one write a cycle). req_tdata:
// data_byte[7:0], palette_index[15:8], palette_color[39:16]; req_tuser: mode.
// rsp_tdata: pixel; rsp_tuser: end_of_row[0], end_of_image[1].
module png_scanline_unfilter import psu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte, palette_index, palette_color
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel
   output logic [1:0]  rsp_tuser,   // end_of_row, end_of_image
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [12:0] width_ff;
   logic [15:0] height_ff;
   logic [2:0]  format_ff;
   logic        acc, smp_valid, pal_we;
   smp_type     smp;
   logic [LINE_AW-1:0] smp_col;

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd1; height_ff <= 16'd1; format_ff <= FMT_GRAY;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            ADDR_WIDTH:  width_ff  <= csr_pwdata[12:0];
            ADDR_HEIGHT: height_ff <= csr_pwdata[15:0];
            ADDR_FORMAT: format_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      unique case (csr_paddr[3:2])
         ADDR_WIDTH:  csr_prdata = {19'd0, width_ff};
         ADDR_HEIGHT: csr_prdata = {16'd0, height_ff};
         ADDR_FORMAT: csr_prdata = {29'd0, format_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

   assign acc = req_tvalid && req_tready;

   psu_front u_front (
      .clock, .reset, .in_valid(acc), .mode(req_tuser), .data_byte(req_tdata[7:0]),
      .cfg_width(width_ff), .cfg_height(height_ff), .cfg_format(format_ff),
      .smp_valid, .smp, .smp_col, .pal_we
   );
   psu_back u_back (
      .clock, .reset, .smp_valid, .smp, .smp_col, .pal_we,
      .pal_idx(req_tdata[15:8]), .pal_color(req_tdata[39:16]),
      .out_ready(rsp_tready), .out_valid(rsp_tvalid), .out_pixel(rsp_tdata),
      .out_eor(rsp_tuser[0]), .out_eoi(rsp_tuser[1]), .accept_ok(req_tready)
   );
endmodule

// File: src/psu_checker.sv
// ----------------------------------------------------------------------------
// psu_checker: port-level assertions
// Watches the result stream and the CSR ready signal of the unfilter.
// ----------------------------------------------------------------------------
module psu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");
   a_eoi: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("end of image without end of row");
   a_rdy: assert property (@(posedge clock) csr_pready)
      else $error("csr not ready");
endmodule

bind png_scanline_unfilter psu_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .csr_pready
);

// File: tb/sv/tb_png_scanline_unfilter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter: self-checking bench for the PNG scanline unfilter
// Streams filtered rows and palette writes through the request channel, works
// out every expected RGBA pixel in its own line-store model, and compares the
// pixels and end flags in order; requests idle, responses stall at random.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;
   import psu_pkg::*;

   localparam int LIMIT_CYCLES = 600000;
   localparam int SETTLE       = 12;
   localparam int LONG_HOLD    = 400;

   typedef struct {
      logic        mode;
      logic [39:0] data;
   } req_item_t;

   typedef struct {
      logic [31:0] pixel;
      logic        eor;
      logic        eoi;
   } pixel_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // data_byte[7:0], palette_index[15:8], palette_color[39:16]
   logic        req_tuser = 1'b0; // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // pixel
   logic [1:0]  rsp_tuser;        // end_of_row[0], end_of_image[1]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   png_scanline_unfilter uut (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- model state
   logic [12:0] m_width;
   logic [15:0] m_height;
   logic [2:0]  m_format;
   logic [7:0]  m_line [LINE_DEPTH];
   logic [7:0]  m_left [4];
   logic [7:0]  m_upl [4];
   logic [2:0]  m_filter;
   int unsigned m_col;
   int unsigned m_row;
   logic [23:0] m_asm;
   logic [23:0] m_pal [PALETTE_DEPTH];
   logic        m_pal_ok [PALETTE_DEPTH];

   req_item_t pending_q[$];
   pixel_t    pixel_q[$];
   int        fails = 0;
   int        samples_sent = 0;
   bit        quiet = 1'b0;
   int        hold_req = 0;

   function automatic int unsigned fmt_bpp(logic [2:0] f);
      case (f)
         FMT_RGB:  return 3;
         FMT_GA:   return 2;
         FMT_RGBA: return 4;
         default:  return 1;
      endcase
   endfunction

   function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int p, ia, ib, ic, da, db, dc;
      ia = int'(a);
      ib = int'(b);
      ic = int'(c);
      p  = ia + ib - ic;
      da = (p > ia) ? p - ia : ia - p;
      db = (p > ib) ? p - ib : ib - p;
      dc = (p > ic) ? p - ic : ic - p;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   // one mode-0 byte through the model; may push one expected pixel
   task automatic unfilter_byte(input logic [7:0] x);
      int unsigned bpp, w, h, rowbytes, i, k;
      logic [7:0] up, left, ul, pred, recon;
      pixel_t px;
      if (m_col == 0) begin
         m_filter = (x <= 4) ? x[2:0] : FLT_NONE;
         m_col = 1;
         for (int j = 0; j < 4; j++) begin
            m_left[j] = '0;
            m_upl[j] = '0;
         end
         m_asm = '0;
         return;
      end
      bpp = fmt_bpp(m_format);
      w = (m_width == 0) ? 1 : m_width;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = (m_height == 0) ? 1 : m_height;
      rowbytes = w * bpp;
      i = m_col - 1;
      up = (m_row != 0 && i < LINE_DEPTH) ? m_line[i] : 8'd0;
      left = m_left[bpp-1];
      ul = m_upl[bpp-1];
      case (m_filter)
         FLT_SUB:   pred = left;
         FLT_UP:    pred = up;
         FLT_AVG:   pred = 8'((9'(left) + 9'(up)) >> 1);
         FLT_PAETH: pred = paeth_pick(left, up, ul);
         default:   pred = '0;
      endcase
      recon = x + pred;
      for (int j = 3; j > 0; j--) begin
         m_left[j] = m_left[j-1];
         m_upl[j] = m_upl[j-1];
      end
      m_left[0] = recon;
      m_upl[0] = up;
      if (i < LINE_DEPTH) m_line[i] = recon;
      k = i % bpp;
      if (k != bpp - 1) begin
         m_asm = m_asm | (24'(recon) << (8 * k));
         m_col = (m_col + 1) & 16'h7fff;
         return;
      end
      case (m_format)
         FMT_RGB:  px.pixel = {8'hff, recon, m_asm[15:0]};
         FMT_PAL:  px.pixel = m_pal_ok[recon] ? {8'hff, m_pal[recon]} : 32'd0;
         FMT_GA:   px.pixel = {recon, {3{m_asm[7:0]}}};
         FMT_RGBA: px.pixel = {recon, m_asm};
         default:  px.pixel = {8'hff, {3{recon}}};
      endcase
      m_asm = '0;
      px.eor = (i + 1 >= rowbytes);
      px.eoi = px.eor && (m_row + 1 >= h);
      if (px.eor) begin
         m_col = 0;
         m_row = px.eoi ? 0 : ((m_row + 1) & 16'hffff);
      end else begin
         m_col = (m_col + 1) & 16'h7fff;
      end
      pixel_q.push_back(px);
   endtask

   task automatic queue_sample(input logic [7:0] x);
      req_item_t it;
      it.mode = 1'b0;
      it.data = {24'($urandom()), 8'($urandom()), x};   // palette fields are don't-care here
      pending_q.push_back(it);
      samples_sent++;
      unfilter_byte(x);
   endtask

   task automatic queue_palette(input logic [7:0] idx, input logic [23:0] color);
      req_item_t it;
      it.mode = 1'b1;
      it.data = {color, idx, 8'($urandom())};
      pending_q.push_back(it);
      m_pal[idx] = color;
      m_pal_ok[idx] = 1'b1;
   endtask

   // wait until the block is idle; every written pixel has come back
   task automatic drain();
      while (pending_q.size() != 0 || pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_cfg(input int w, input int h, input int f);
      drain();
      csr_write(ADDR_WIDTH, w);
      csr_write(ADDR_HEIGHT, h);
      csr_write(ADDR_FORMAT, f);
      m_width = 13'(w);
      m_height = 16'(h);
      m_format = 3'(f);
   endtask

   // filter byte, then one row of random samples; sparse palette writes mixed in
   task automatic send_row(input int filt);
      int unsigned w, n;
      w = (m_width == 0) ? 1 : m_width;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      n = w * fmt_bpp(m_format);
      queue_sample(8'(filt));
      for (int unsigned j = 0; j < n; j++) begin
         if ($urandom_range(0, 9) == 0)
            queue_palette(8'($urandom()), 24'($urandom()));
         queue_sample(8'($urandom()));
      end
   endtask

   function automatic int rand_filter();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 255);
   endfunction

   task automatic send_image(input int w, input int h, input int f);
      int rows;
      set_cfg(w, h, f);
      rows = (h == 0) ? 1 : h;
      for (int r = 0; r < rows; r++) send_row(rand_filter());
   endtask

   // ------------------------------------------------------------------ stimulus
   initial begin
      int fv;
      for (int j = 0; j < LINE_DEPTH; j++) m_line[j] = '0;
      for (int j = 0; j < PALETTE_DEPTH; j++) begin
         m_pal[j] = '0;
         m_pal_ok[j] = 1'b0;
      end
      for (int j = 0; j < 4; j++) begin
         m_left[j] = '0;
         m_upl[j] = '0;
      end
      m_width = 1; m_height = 1; m_format = FMT_GRAY;
      m_filter = FLT_NONE; m_col = 0; m_row = 0; m_asm = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: every filter code plus unknown codes 5, 7 and 255, extreme samples
      set_cfg(2, 8, FMT_GRAY);
      for (int r = 0; r < 8; r++) begin
         fv = (r < 5) ? r : ((r == 5) ? 5 : ((r == 6) ? 7 : 255));
         queue_sample(8'(fv));
         queue_sample(8'hff);
         queue_sample(8'h00);
      end
      // palette: extreme entries, one unwritten entry read
      queue_palette(8'd0, 24'h000000);
      queue_palette(8'd255, 24'hffffff);
      set_cfg(2, 1, FMT_PAL);
      queue_sample(8'd0); queue_sample(8'd255); queue_sample(8'd77);
      // width 0, height 0, bad format
      set_cfg(0, 0, 7);
      send_row(FLT_PAETH);

      // random images, mostly tiny; one long receiver hold-off in the middle
      while (samples_sent < 520) begin
         if (samples_sent > 250 && hold_req == 0) begin
            set_cfg(16, 2, FMT_RGB);
            hold_req = 1;
            for (int r = 0; r < 2; r++) send_row(rand_filter());
         end else begin
            send_image(($urandom_range(0, 15) == 0) ? $urandom_range(0, 12)
                                                    : $urandom_range(1, 6),
                       $urandom_range(0, 4), $urandom_range(0, 7));
         end
      end

      // height at its top, then cut short mid-image
      set_cfg(1, 65535, FMT_GRAY);
      send_row(FLT_UP); send_row(FLT_SUB);
      set_cfg(1, 1, FMT_GRAY);
      send_row(FLT_AVG);
      // row length shrinks mid-image
      set_cfg(8, 4, FMT_RGBA);
      send_row(FLT_NONE); send_row(FLT_PAETH);
      set_cfg(5, 4, FMT_GA);
      send_row(FLT_UP); send_row(FLT_PAETH);

      // last stretch: no idling on either side
      drain();
      quiet = 1'b1;
      send_image(5, 3, FMT_RGBA);
      send_image(3, 2, FMT_PAL);

      drain();
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("png_scanline_unfilter verification clean");
      end else begin
         $display("png_scanline_unfilter verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------ driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) pending_q.pop_front();
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!quiet && !(req_tvalid && !req_tready) &&
                      $urandom_range(0, 11) == 0) begin
            // a request on offer stays until taken; idle only between requests
            send_gap <= $urandom_range(0, 15);
            req_tvalid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_q[0].data;
            req_tuser <= pending_q[0].mode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------ monitor
   int stall = 0;
   int hold_seen = 0;
   always @(posedge clock) begin
      pixel_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_q.size() == 0) begin
               $error("unexpected pixel %h", rsp_tdata);
               fails++;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  $error("pixel: expected %h, got %h", want.pixel, rsp_tdata);
                  fails++;
               end
               if (rsp_tuser[0] !== want.eor) begin
                  $error("end_of_row: expected %b, got %b", want.eor, rsp_tuser[0]);
                  fails++;
               end
               if (rsp_tuser[1] !== want.eoi) begin
                  $error("end_of_image: expected %b, got %b", want.eoi, rsp_tuser[1]);
                  fails++;
               end
            end
         end
         if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            stall <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall <= $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------ watchdog
   int cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("png_scanline_unfilter verification failed");
         $finish;
      end
   end

endmodule

// File: filelist.f
src/psu_pkg.sv
src/psu_front.sv
src/psu_back.sv
src/png_scanline_unfilter.sv
src/psu_checker.sv
tb/sv/tb_png_scanline_unfilter.sv
